FILE: rtl/lzss_adaptive_huffman_decoder_assert.svh
// Assertion macros for the decoder block.
// Needs clk and arst_n in the scope of every use.
`ifndef LZSS_ADAPTIVE_HUFFMAN_DECODER_ASSERT_SVH
`define LZSS_ADAPTIVE_HUFFMAN_DECODER_ASSERT_SVH
// condition that must hold at every clock edge out of reset
`define LAHD_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("lahd check failed");
// condition that must hold in the cycle after the trigger
`define LAHD_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lahd sequence check failed");
`endif

FILE: rtl/lahd_pkg.sv
// Shared constants, types and the position head decoder of the decoder block.
// No dependencies.
package lahd_pkg;
	localparam int DICT_SIZE  = 4096;
	localparam int MAX_MATCH  = 60;
	localparam int FREQ_LIMIT = 32768;
	localparam int NCHAR      = 256 - 2 + MAX_MATCH;
	localparam int NODES      = NCHAR * 2 - 1;
	localparam int ROOT       = NODES - 1;
	localparam int NODE_W     = $clog2(NODES + NCHAR);
	localparam int SYM_W      = $clog2(NCHAR);
	localparam int HIST_AW    = $clog2(DICT_SIZE);
	localparam int HIST_START = DICT_SIZE - MAX_MATCH;
	localparam int ROOT_CHILD0 = 2 * (ROOT - NCHAR);
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);

	localparam logic [NODE_W-1:0] NODES_N = NODE_W'(NODES);
	localparam logic [NODE_W-1:0] ROOT_N  = NODE_W'(ROOT);
	localparam logic [NODE_W-1:0] NCHAR_N = NODE_W'(NCHAR);

	localparam logic [1:0] PH_SYM   = 2'd0;
	localparam logic [1:0] PH_HEAD  = 2'd1;
	localparam logic [1:0] PH_TAIL  = 2'd2;
	localparam logic [1:0] PH_ENDED = 2'd3;

	localparam logic [1:0] STAT_DEC = 2'd0;
	localparam logic [1:0] STAT_OK  = 2'd1;
	localparam logic [1:0] STAT_ERR = 2'd2;

	typedef struct packed {
		logic bit_value;
		logic stream_end;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        run_last;
		logic [1:0]  status;
		logic [31:0] bytes_written;
	} res_t;

	// 8-bit head -> {6-bit high part, count of extra bits}
	function automatic logic [8:0] head_split(input logic [7:0] h);
		logic [5:0] code;
		logic [2:0] extra;
		if (h < 8'd32) begin
			code = 6'd0;
			extra = 3'd1;
		end else if (h < 8'd80) begin
			code = 6'd1 + 6'((h - 8'd32) >> 4);
			extra = 3'd2;
		end else if (h < 8'd144) begin
			code = 6'd4 + 6'((h - 8'd80) >> 3);
			extra = 3'd3;
		end else if (h < 8'd192) begin
			code = 6'd12 + 6'((h - 8'd144) >> 2);
			extra = 3'd4;
		end else if (h < 8'd240) begin
			code = 6'd24 + 6'((h - 8'd192) >> 1);
			extra = 3'd5;
		end else begin
			code = 6'd48 + 6'(h - 8'd240);
			extra = 3'd6;
		end
		return {code, extra};
	endfunction
endpackage

FILE: rtl/lahd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lahd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we && (int'(waddr) < DEPTH)) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/lahd_front.sv
// Input side: takes bit transactions and queues them for the decode engine.
// Depends on lahd_pkg.
module lahd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            enable,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,
	input  logic            s_tuser,
	output logic            q_valid,
	output lahd_pkg::item_t q_item,
	input  logic            q_pop
);
	import lahd_pkg::*;

	item_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wp_q, rp_q;
	logic [QAW:0]     cnt_q;
	logic             push;

	assign s_tready = enable && (cnt_q != (QAW+1)'(QDEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{bit_value: s_tdata[0], stream_end: s_tuser};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			if (push && !q_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

FILE: rtl/lahd_engine.sv
// Decode engine: tree walk and update, rebuild, position decode, window copy.
// Depends on lahd_pkg, lahd_ram and the assertion header.
`include "lzss_adaptive_huffman_decoder_assert.svh"
module lahd_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     output_length,
	input  logic            q_valid,
	input  lahd_pkg::item_t q_item,
	output logic            q_pop,
	output logic            init_done,
	output lahd_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_ready
);
	import lahd_pkg::*;

	localparam logic [5:0] ST_ILEAF = 6'd0,  ST_IA    = 6'd1,  ST_IB    = 6'd2;
	localparam logic [5:0] ST_IC    = 6'd3,  ST_ID    = 6'd4,  ST_IFIN  = 6'd5;
	localparam logic [5:0] ST_IWAIT = 6'd6,  ST_IDLE  = 6'd7,  ST_SYMRD = 6'd8;
	localparam logic [5:0] ST_UROOT = 6'd9,  ST_UP0   = 6'd10, ST_UPAR  = 6'd11;
	localparam logic [5:0] ST_UN    = 6'd12, ST_UW    = 6'd13, ST_UCMP  = 6'd14;
	localparam logic [5:0] ST_USCAN = 6'd15, ST_UCHK  = 6'd16, ST_UA    = 6'd17;
	localparam logic [5:0] ST_UB    = 6'd18, ST_UC    = 6'd19, ST_UD    = 6'd20;
	localparam logic [5:0] ST_UPRD  = 6'd21, ST_UUP   = 6'd22, ST_UDONE = 6'd23;
	localparam logic [5:0] ST_LIT   = 6'd24, ST_STAT  = 6'd25, ST_CPRD  = 6'd26;
	localparam logic [5:0] ST_CPEM  = 6'd27, ST_R1A   = 6'd28, ST_R1B   = 6'd29;
	localparam logic [5:0] ST_R2A   = 6'd30, ST_R2B   = 6'd31, ST_R2C   = 6'd32;
	localparam logic [5:0] ST_R2S   = 6'd33, ST_R2T   = 6'd34, ST_R2W   = 6'd35;
	localparam logic [5:0] ST_R3A   = 6'd36, ST_R3B   = 6'd37, ST_R3C   = 6'd38;

	logic [5:0]         state_q;
	logic               init_done_q;
	logic [1:0]         phase_q;
	logic               err_q;
	logic [31:0]        produced_q;
	logic [NODE_W-1:0]  walk_q, rc_q;
	logic [13:0]        accum_q;
	logic [3:0]         left_q, spare_q;
	logic [5:0]         pend_q, cnt_q;
	logic [HIST_AW-1:0] hpos_q, src_q, hcnt_q;
	logic               hinit_q;
	logic [SYM_W-1:0]   sym_q;
	logic [NODE_W-1:0]  i_q, j_q, k_q, loc_q, n_q, o_q, a_q, b_q;
	logic [16:0]        w_q, f_q;
	logic [15:0]        wo_q;
	res_t               res_q;
	logic               res_valid_q;

	// memory ports
	logic              w_we, p_we, c_we, h_we;
	logic [NODE_W-1:0] w_waddr, w_raddr, p_waddr, p_raddr, c_waddr, c_raddr;
	logic [15:0]       w_wdata, w_rdata;
	logic [NODE_W-1:0] p_wdata, p_rdata, c_wdata, c_rdata;
	logic [HIST_AW-1:0] h_waddr, h_raddr;
	logic [7:0]        h_wdata, h_rdata;

	lahd_ram #(.WIDTH(16), .DEPTH(NODES + 1)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata));
	lahd_ram #(.WIDTH(NODE_W), .DEPTH(NODES + NCHAR)) u_parent (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));
	lahd_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_child (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata));
	lahd_ram #(.WIDTH(8), .DEPTH(DICT_SIZE)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata));

	logic               can_load, res_load;
	res_t               res_d;
	logic [1:0]         status_now;
	logic [NODE_W:0]    idx;
	logic [NODE_W-1:0]  ii;
	logic [7:0]         t_low, h_acc;
	logic [8:0]         split;
	logic [3:0]         left_dec;
	logic [11:0]        pos_dist;
	logic [HIST_AW-1:0] src_d;
	logic [31:0]        room;
	logic               end_ok;
	logic [16:0]        w_inc;

	assign can_load   = !res_valid_q || res_ready;
	assign status_now = (phase_q == PH_ENDED) ? (err_q ? STAT_ERR : STAT_OK)
	                                          : (err_q ? STAT_ERR : STAT_DEC);
	assign idx        = {1'b0, walk_q} + {{NODE_W{1'b0}}, q_item.bit_value};
	assign ii         = NODE_W'((k_q - NCHAR_N) << 1);
	assign t_low      = {accum_q[6:0], q_item.bit_value};
	assign h_acc      = t_low;
	assign split      = head_split(h_acc);
	assign left_dec   = (left_q == 4'd0) ? 4'd0 : left_q - 4'd1;
	assign pos_dist   = {accum_q[13:8], t_low[5:0]};
	assign src_d      = hpos_q - HIST_AW'(pos_dist) - HIST_AW'(1);
	assign room       = (produced_q < output_length) ? output_length - produced_q : 32'd0;
	assign end_ok     = !err_q && (phase_q == PH_SYM) && (walk_q == rc_q) &&
	                    (produced_q == output_length) && (spare_q < 4'd8);
	assign w_inc      = {1'b0, w_rdata} + 17'd1;
	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign init_done  = init_done_q;
	assign res        = res_q;
	assign res_valid  = res_valid_q;

	always_comb begin
		w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;
		p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
		c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
		h_we = 1'b0; h_waddr = hpos_q; h_wdata = '0;
		h_raddr = src_q + HIST_AW'(cnt_q);
		res_load = 1'b0;
		res_d = '{out_byte: 8'd0, byte_valid: 1'b0, run_last: 1'b1,
		          status: status_now, bytes_written: produced_q};
		if (hinit_q) begin
			h_we    = 1'b1;
			h_waddr = hcnt_q;
			h_wdata = (hcnt_q >= HIST_AW'(HIST_START)) ? 8'h00 : 8'h20;
		end
		unique case (state_q)
			ST_ILEAF: begin
				w_we = 1'b1; w_waddr = i_q; w_wdata = 16'd1;
				c_we = 1'b1; c_waddr = i_q; c_wdata = i_q + NODES_N;
				p_we = 1'b1; p_waddr = i_q + NODES_N; p_wdata = i_q;
			end
			ST_IA: w_raddr = ii;
			ST_IB: w_raddr = ii + 1'b1;
			ST_IC: begin
				w_we = 1'b1; w_waddr = k_q; w_wdata = f_q[15:0] + w_rdata;
				c_we = 1'b1; c_waddr = k_q; c_wdata = ii;
				p_we = 1'b1; p_waddr = ii; p_wdata = k_q;
			end
			ST_ID: begin
				p_we = 1'b1; p_waddr = ii + 1'b1; p_wdata = k_q;
			end
			ST_IFIN: begin
				w_we = 1'b1; w_waddr = NODES_N; w_wdata = 16'hffff;
				p_we = 1'b1; p_waddr = ROOT_N; p_wdata = '0;
			end
			ST_IWAIT: ;
			ST_IDLE: c_raddr = idx[NODE_W-1:0];
			ST_SYMRD: w_raddr = ROOT_N;
			ST_UROOT: ;
			ST_UP0, ST_UPRD: p_raddr = n_q;
			ST_UPAR: ;
			ST_UN: w_raddr = n_q;
			ST_UW: begin
				w_we = 1'b1; w_waddr = n_q; w_wdata = w_inc[15:0];
				w_raddr = n_q + 1'b1;
			end
			ST_UCMP: w_raddr = o_q + 1'b1;
			ST_USCAN: w_raddr = o_q + NODE_W'(2);
			ST_UCHK: begin
				if (o_q < NODES_N) begin
					w_we = 1'b1; w_waddr = n_q; w_wdata = wo_q;
				end
				c_raddr = n_q;
			end
			ST_UA: begin
				w_we = 1'b1; w_waddr = o_q; w_wdata = w_q[15:0];
				p_we = 1'b1; p_waddr = c_rdata; p_wdata = o_q;
				c_raddr = o_q;
			end
			ST_UB: begin
				if (a_q < NODES_N) begin
					p_we = 1'b1; p_waddr = a_q + 1'b1; p_wdata = o_q;
				end
				c_we = 1'b1; c_waddr = o_q; c_wdata = a_q;
			end
			ST_UC: begin
				p_we = 1'b1; p_waddr = b_q; p_wdata = n_q;
				c_we = 1'b1; c_waddr = n_q; c_wdata = b_q;
			end
			ST_UD: begin
				if (b_q < NODES_N) begin
					p_we = 1'b1; p_waddr = b_q + 1'b1; p_wdata = n_q;
				end
			end
			ST_UUP, ST_UDONE: ;
			ST_LIT: begin
				res_load = can_load;
				res_d.out_byte = sym_q[7:0];
				res_d.byte_valid = 1'b1;
				res_d.bytes_written = produced_q + 32'd1;
				if (can_load) begin
					h_we = 1'b1; h_wdata = sym_q[7:0];
				end
			end
			ST_STAT: res_load = can_load;
			ST_CPRD: ;
			ST_CPEM: begin
				res_load = can_load;
				res_d.out_byte = h_rdata;
				res_d.byte_valid = 1'b1;
				res_d.run_last = ((cnt_q + 6'd1) == pend_q);
				res_d.bytes_written = produced_q + 32'd1;
				if (can_load) begin
					h_we = 1'b1; h_wdata = h_rdata;
				end
			end
			ST_R1A: begin
				c_raddr = i_q; w_raddr = i_q;
			end
			ST_R1B: begin
				if (c_rdata >= NODES_N) begin
					w_we = 1'b1; w_waddr = j_q; w_wdata = w_inc[16:1];
					c_we = 1'b1; c_waddr = j_q; c_wdata = c_rdata;
				end
			end
			ST_R2A: w_raddr = ii;
			ST_R2B: w_raddr = ii + 1'b1;
			ST_R2C: ;
			ST_R2S: begin
				w_raddr = loc_q - 1'b1; c_raddr = loc_q - 1'b1;
			end
			ST_R2T: begin
				if (f_q < {1'b0, w_rdata}) begin
					w_we = 1'b1; w_waddr = loc_q; w_wdata = w_rdata;
					c_we = 1'b1; c_waddr = loc_q; c_wdata = c_rdata;
				end
			end
			ST_R2W: begin
				w_we = 1'b1; w_waddr = loc_q; w_wdata = f_q[15:0];
				c_we = 1'b1; c_waddr = loc_q; c_wdata = ii;
			end
			ST_R3A: c_raddr = i_q;
			ST_R3B: begin
				p_we = 1'b1; p_waddr = c_rdata; p_wdata = i_q;
			end
			ST_R3C: begin
				p_we = 1'b1; p_waddr = a_q + 1'b1; p_wdata = i_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ILEAF;
			init_done_q <= 1'b0;
			phase_q     <= PH_SYM;
			err_q       <= 1'b0;
			produced_q  <= '0;
			walk_q      <= NODE_W'(ROOT_CHILD0);
			rc_q        <= NODE_W'(ROOT_CHILD0);
			accum_q     <= '0;
			left_q      <= '0;
			spare_q     <= '0;
			pend_q      <= '0;
			cnt_q       <= '0;
			hpos_q      <= HIST_AW'(HIST_START);
			src_q       <= '0;
			hcnt_q      <= '0;
			hinit_q     <= 1'b1;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= NCHAR_N;
			res_valid_q <= 1'b0;
		end else begin
			if (hinit_q) begin
				hcnt_q <= hcnt_q + 1'b1;
				if (hcnt_q == {HIST_AW{1'b1}}) hinit_q <= 1'b0;
			end
			if (c_we && (c_waddr == ROOT_N)) rc_q <= c_wdata;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (res_load && res_d.byte_valid) begin
				hpos_q     <= hpos_q + 1'b1;
				produced_q <= produced_q + 32'd1;
			end

			unique case (state_q)
				ST_ILEAF: begin
					i_q <= i_q + 1'b1;
					if (i_q == NCHAR_N - 1'b1) begin
						k_q <= NCHAR_N;
						state_q <= ST_IA;
					end
				end
				ST_IA: state_q <= ST_IB;
				ST_IB: begin
					f_q <= {1'b0, w_rdata};
					state_q <= ST_IC;
				end
				ST_IC: state_q <= ST_ID;
				ST_ID: begin
					k_q <= k_q + 1'b1;
					state_q <= (k_q == ROOT_N) ? ST_IFIN : ST_IA;
				end
				ST_IFIN: state_q <= ST_IWAIT;
				ST_IWAIT: begin
					if (!hinit_q) begin
						init_done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_STAT;
						if (phase_q == PH_ENDED) begin
							// ended: report the final status again
						end else if (q_item.stream_end) begin
							if (!end_ok) err_q <= 1'b1;
							phase_q <= PH_ENDED;
						end else if (!err_q) begin
							unique case (phase_q)
								PH_SYM: begin
									if (walk_q == rc_q && produced_q >= output_length) begin
										if (spare_q != 4'd15) spare_q <= spare_q + 4'd1;
									end else if (idx >= {1'b0, NODES_N}) begin
										err_q <= 1'b1;
									end else begin
										state_q <= ST_SYMRD;
									end
								end
								PH_HEAD: begin
									left_q <= left_dec;
									if (left_dec == 4'd0) begin
										accum_q <= {split[8:3], h_acc};
										left_q  <= {1'b0, split[2:0]};
										phase_q <= PH_TAIL;
									end else begin
										accum_q <= {6'd0, h_acc};
									end
								end
								PH_TAIL: begin
									accum_q <= {accum_q[13:8], t_low};
									left_q  <= left_dec;
									if (left_dec == 4'd0) begin
										phase_q <= PH_SYM;
										if (32'(pend_q) > room) begin
											err_q <= 1'b1;
										end else begin
											src_q <= src_d;
											cnt_q <= '0;
											state_q <= ST_CPRD;
										end
									end
								end
								PH_ENDED: ;
							endcase
						end
					end
				end
				ST_SYMRD: begin
					if (c_rdata < NODES_N) begin
						walk_q <= c_rdata;
						state_q <= ST_STAT;
					end else if (c_rdata - NODES_N >= NCHAR_N) begin
						err_q <= 1'b1;
						state_q <= ST_STAT;
					end else begin
						sym_q <= SYM_W'(c_rdata - NODES_N);
						state_q <= ST_UROOT;
					end
				end
				ST_UROOT: begin
					if (w_rdata == 16'(FREQ_LIMIT)) begin
						i_q <= '0;
						j_q <= '0;
						state_q <= ST_R1A;
					end else begin
						n_q <= NODE_W'(sym_q) + NODES_N;
						state_q <= ST_UP0;
					end
				end
				ST_UP0: state_q <= ST_UPAR;
				ST_UPAR: begin
					n_q <= p_rdata;
					state_q <= ST_UN;
				end
				ST_UN: begin
					if (n_q >= NODES_N) begin
						err_q <= 1'b1;
						state_q <= ST_UDONE;
					end else begin
						state_q <= ST_UW;
					end
				end
				ST_UW: begin
					w_q <= w_inc;
					o_q <= n_q + 1'b1;
					state_q <= ST_UCMP;
				end
				ST_UCMP: begin
					wo_q <= w_rdata;
					if (w_q > {1'b0, w_rdata}) begin
						state_q <= (o_q < NODES_N) ? ST_USCAN : ST_UCHK;
					end else begin
						state_q <= ST_UPRD;
					end
				end
				ST_USCAN: begin
					if (w_q > {1'b0, w_rdata}) begin
						o_q  <= o_q + 1'b1;
						wo_q <= w_rdata;
						state_q <= (o_q + 1'b1 < NODES_N) ? ST_USCAN : ST_UCHK;
					end else begin
						state_q <= ST_UCHK;
					end
				end
				ST_UCHK: begin
					if (o_q >= NODES_N) begin
						err_q <= 1'b1;
						state_q <= ST_UDONE;
					end else begin
						state_q <= ST_UA;
					end
				end
				ST_UA: begin
					a_q <= c_rdata;
					state_q <= ST_UB;
				end
				ST_UB: begin
					b_q <= c_rdata;
					state_q <= ST_UC;
				end
				ST_UC: state_q <= ST_UD;
				ST_UD: begin
					n_q <= o_q;
					state_q <= ST_UPRD;
				end
				ST_UPRD: state_q <= ST_UUP;
				ST_UUP: begin
					n_q <= p_rdata;
					state_q <= (p_rdata == '0) ? ST_UDONE : ST_UN;
				end
				ST_UDONE: begin
					walk_q <= rc_q;
					if (err_q) begin
						state_q <= ST_STAT;
					end else if (sym_q < SYM_W'(256)) begin
						state_q <= ST_LIT;
					end else begin
						pend_q  <= 6'(sym_q - SYM_W'(253));
						accum_q <= '0;
						left_q  <= 4'd8;
						phase_q <= PH_HEAD;
						state_q <= ST_STAT;
					end
				end
				ST_LIT, ST_STAT: begin
					if (can_load) state_q <= ST_IDLE;
				end
				ST_CPRD: state_q <= ST_CPEM;
				ST_CPEM: begin
					if (can_load) begin
						cnt_q <= cnt_q + 6'd1;
						state_q <= ((cnt_q + 6'd1) == pend_q) ? ST_IDLE : ST_CPRD;
					end
				end
				ST_R1A: state_q <= ST_R1B;
				ST_R1B: begin
					i_q <= i_q + 1'b1;
					if (c_rdata >= NODES_N) j_q <= j_q + 1'b1;
					if (i_q == ROOT_N) begin
						k_q <= NCHAR_N;
						state_q <= ST_R2A;
					end else begin
						state_q <= ST_R1A;
					end
				end
				ST_R2A: state_q <= ST_R2B;
				ST_R2B: begin
					f_q <= {1'b0, w_rdata};
					state_q <= ST_R2C;
				end
				ST_R2C: begin
					f_q <= f_q + {1'b0, w_rdata};
					loc_q <= k_q;
					state_q <= ST_R2S;
				end
				ST_R2S: state_q <= (loc_q != '0) ? ST_R2T : ST_R2W;
				ST_R2T: begin
					if (f_q < {1'b0, w_rdata}) begin
						loc_q <= loc_q - 1'b1;
						state_q <= ST_R2S;
					end else begin
						state_q <= ST_R2W;
					end
				end
				ST_R2W: begin
					k_q <= k_q + 1'b1;
					if (k_q == ROOT_N) begin
						i_q <= '0;
						state_q <= ST_R3A;
					end else begin
						state_q <= ST_R2A;
					end
				end
				ST_R3A: state_q <= ST_R3B;
				ST_R3B, ST_R3C: begin
					if (state_q == ST_R3B && c_rdata < NODES_N) begin
						a_q <= c_rdata;
						state_q <= ST_R3C;
					end else if (i_q == ROOT_N) begin
						n_q <= NODE_W'(sym_q) + NODES_N;
						state_q <= ST_UP0;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_R3A;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_d;
	end

	`LAHD_CHECK(a_pop_only_idle, !q_pop || (state_q == ST_IDLE && init_done_q))
	`LAHD_CHECK_NEXT(a_ended_sticks, phase_q == PH_ENDED, phase_q == PH_ENDED)
	`LAHD_CHECK_NEXT(a_spare_saturates, spare_q == 4'd15, spare_q == 4'd15)
	`LAHD_CHECK(a_hist_write_emits, !h_we || hinit_q || (res_load && res_d.byte_valid))
endmodule

FILE: rtl/lzss_adaptive_huffman_decoder.sv
// Engine: a walk bit is popped from the queue and its child read; the weight update climbs
// the tree level by level, scanning for a swap partner where nodes swap; a match copy reads
// each byte from the window, then emits it. The one read port of each tree memory sets the
// pace; a tree rebuild (root weight at the limit) runs an insertion sort over the entries.
// Reset: asynchronous, active low; then an init pass fills the history window and
// builds the start tree, with s_tready low, while configuration writes are still taken.
module lzss_adaptive_huffman_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,     // output_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [0] bit_value, [7:1] zero
	input  logic        s_tuser,       // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,       // [7:0] out_byte, [9:8] status,
	                                   // [41:10] bytes_written, [47:42] zero
	output logic        m_tuser,       // byte_valid
	output logic        m_tlast        // run_last
);
	import lahd_pkg::*;

	logic [31:0] olen_q;   // output_length register
	logic        q_valid, q_pop, init_done;
	item_t       q_item;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olen_q <= '0;
		end else if (cfg_we) begin
			olen_q <= cfg_wdata;
		end
	end

	// front: bit transactions into a short queue
	lahd_front u_front (
		.clk(clk), .arst_n(arst_n), .enable(init_done),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

	// back: tree, window and output register
	lahd_engine u_engine (
		.clk(clk), .arst_n(arst_n), .output_length(olen_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .init_done(init_done),
		.res(res), .res_valid(m_tvalid), .res_ready(m_tready));

	assign m_tdata = {6'd0, res.bytes_written, res.status, res.out_byte};
	assign m_tuser = res.byte_valid;
	assign m_tlast = res.run_last;
endmodule
